@@ rtl/lsr_pkg.sv @@
// Package with the shared types and constants of the LIFO stack with replace.
package lsr_pkg;

  // Field widths fixed by the interface.
  localparam int OPCODE_BITS = 2;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 8;
  localparam int CAP_BITS    = 8;

  // Capacity register value after reset.
  localparam logic [CAP_BITS-1:0] CAP_RESET = 8'd100;

  // Request codes.
  typedef enum logic [OPCODE_BITS-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_REPLACE = 2'd3
  } opcode_t;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_REPL,
    S_OUT
  } state_t;

endpackage

@@ rtl/lifo_stack_with_replace.sv @@
// LIFO stack of signed words with push, pop, peek and replace-all requests.
//
// One request is handled at a time. Push, and pop or peek on an empty stack,
// show their result in the cycle after the transfer; pop and peek on a
// non-empty stack first pass through a read state, as the entry memory has a
// registered read port. Replace-all walks the held entries through that
// memory with a pipelined read-compare-write. The result stays on the output
// until it is taken, and the next request is taken in the cycle after that.
// The stack holds up to DEPTH entries, further limited by the capacity
// register (reset value 100); a full push or an empty pop is refused with an
// error status and leaves the stack unchanged. The entry memory needs no
// clearing after reset.
module lifo_stack_with_replace
  import lsr_pkg::*;
#(
  parameter int DEPTH     = 128,
  parameter int WORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // Request channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [OPCODE_BITS-1:0]      opcode,
  input  logic signed [WORD_BITS-1:0] value,
  input  logic signed [WORD_BITS-1:0] match_value,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] data,
  output logic [STATUS_BITS-1:0]      status,
  output logic [COUNT_BITS-1:0]       count,
  output logic                        is_empty,
  output logic                        is_full,
  // Capacity register write port.
  input  logic                        cfg_we,
  input  logic [CAP_BITS-1:0]         cfg_wdata
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

  // Registers.
  state_t                      state, state_next;
  logic [CW-1:0]               entry_count, entry_count_next;
  logic [CW-1:0]               walk_idx, walk_idx_next;
  logic                        cmp_valid, cmp_valid_next;
  logic [AW-1:0]               cmp_addr, cmp_addr_next;
  logic signed [WORD_BITS-1:0] value_reg, match_reg;
  logic signed [WORD_BITS-1:0] data_reg, data_next;
  status_t                     status_reg, status_next;
  logic [CAP_BITS-1:0]         capacity_reg;

  // Entry memory and its ports.
  logic [WORD_BITS-1:0]        mem [DEPTH];
  logic [WORD_BITS-1:0]        rd_data;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [AW-1:0]               mem_raddr;
  logic [WORD_BITS-1:0]        mem_wdata;

  logic                        in_accept;
  logic                        stack_empty;
  logic                        stack_full;
  logic [CMPW-1:0]             cap_ext;
  logic [CMPW-1:0]             eff_cap;
  logic [CW-1:0]               top_idx;

  // Effective capacity is the register value clamped to the depth.
  assign cap_ext     = CMPW'(capacity_reg);
  assign eff_cap     = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
  assign stack_empty = (entry_count == '0);
  assign stack_full  = (CMPW'(entry_count) >= eff_cap);
  assign top_idx     = entry_count - CW'(1);

  // Handshake: one request in flight at a time.
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);

  // Result fields.
  assign data     = data_reg;
  assign status   = status_reg;
  assign count    = COUNT_BITS'(entry_count);
  assign is_empty = stack_empty;
  assign is_full  = stack_full;

  // Next state, datapath updates and memory port control.
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    walk_idx_next    = walk_idx;
    cmp_valid_next   = cmp_valid;
    cmp_addr_next    = cmp_addr;
    data_next        = data_reg;
    status_next      = status_reg;
    mem_we           = 1'b0;
    mem_waddr        = entry_count[AW-1:0];
    mem_wdata        = value;
    mem_raddr        = (state == S_REPL) ? walk_idx[AW-1:0] : top_idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          data_next   = '0;
          status_next = ST_OK;
          case (opcode_t'(opcode))
            OP_PUSH: begin
              state_next = S_OUT;
              if (stack_full) begin
                status_next = ST_FULL;
              end else begin
                mem_we           = 1'b1;
                entry_count_next = entry_count + CW'(1);
                data_next        = value;
              end
            end
            OP_POP: begin
              if (stack_empty) begin
                status_next = ST_EMPTY;
                state_next  = S_OUT;
              end else begin
                entry_count_next = top_idx;
                state_next       = S_READ;
              end
            end
            OP_PEEK: begin
              if (stack_empty) begin
                data_next  = '1;
                state_next = S_OUT;
              end else begin
                state_next = S_READ;
              end
            end
            default: begin
              walk_idx_next  = '0;
              cmp_valid_next = 1'b0;
              state_next     = S_REPL;
            end
          endcase
        end
      end

      // The top entry arrives from the memory.
      S_READ: begin
        data_next  = signed'(rd_data);
        state_next = S_OUT;
      end

      // Read entry walk_idx while comparing and rewriting the one read before.
      S_REPL: begin
        if (cmp_valid && (rd_data == match_reg)) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_addr;
          mem_wdata = value_reg;
        end
        if (walk_idx < entry_count) begin
          cmp_valid_next = 1'b1;
          cmp_addr_next  = walk_idx[AW-1:0];
          walk_idx_next  = walk_idx + CW'(1);
        end else begin
          cmp_valid_next = 1'b0;
          if (!cmp_valid) begin
            state_next = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      walk_idx     <= '0;
      cmp_valid    <= 1'b0;
      capacity_reg <= CAP_RESET;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      walk_idx    <= walk_idx_next;
      cmp_valid   <= cmp_valid_next;
      if (cfg_we) begin
        capacity_reg <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_addr   <= cmp_addr_next;
    data_reg   <= data_next;
    status_reg <= status_next;
    if (in_accept) begin
      value_reg <= value;
      match_reg <= match_value;
    end
  end

  // Entry memory with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  // The entry count never exceeds the depth.
  assert property (@(posedge clk) disable iff (rst) CW'(entry_count) <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // The count does not move while a replace walks the stack.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_REPL) |=> (entry_count == $past(entry_count)))
    else $error("entry count changed during replace");

  // The memory is written only on a push transfer or during a replace.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (in_accept || state == S_REPL))
    else $error("memory write outside push or replace");

  // A pending result blocks new requests.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("request taken while a result is pending");
`endif

endmodule
